// ===== rtl/m3i_pkg.sv =====
package m3i_pkg;

    localparam int ELEM_COUNT = 9;
    localparam int IDX_W      = 4;
    localparam int DATA_W     = 32;
    localparam int OPND_W     = 33;   // element widened to share the signed multiplier
    localparam int PROD_W     = 66;
    localparam int COF_W      = 65;
    localparam int DET_W      = 98;
    localparam int QUO_W      = 33;
    localparam int PH_W       = 3;
    localparam int BIT_W      = 6;
    localparam int LAST_BIT   = 32;   // first quotient bit developed after the overflow test

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_COF,
        ST_DET,
        ST_CHECK,
        ST_PREP,
        ST_ITER,
        ST_EMIT
    } state_t;

    // Source indexes a, b, c, d of cofactor k = a*b - c*d.
    localparam idx_t COF_SEL [ELEM_COUNT][4] = '{
        '{4'd4, 4'd8, 4'd7, 4'd5},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd3, 4'd2, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd6, 4'd4},
        '{4'd6, 4'd1, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd3, 4'd1}
    };

    localparam logic [QUO_W-1:0] LIMIT_POS = 33'h7FFF_FFFF;
    localparam logic [QUO_W-1:0] LIMIT_NEG = 33'h8000_0000;

endpackage

// ===== rtl/m3i_ram.sv =====
module m3i_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/matrix3_inverse_unit.sv =====
// 3x3 matrix inverse by the adjugate method, signed fixed point with FRAC_BITS
// fraction bits (Q16.16 by default). Send nine words in row-major order on the
// s_ channel; after the ninth the unit answers on the m_ channel with nine
// inverse words in row-major order (m_last on the ninth), each the cofactor
// divided by the exact determinant, rounded to nearest with ties away from zero
// and saturated to the 32-bit range. A matrix with a zero determinant gives a
// single word with m_singular and m_last set and a zero element. Loading holds
// s_ready high until the ninth word. The nine cofactors and then the determinant
// are all formed through one shared 33x33 signed multiplier that
// reads the source memory one word per cycle. Each inverse word is then set by
// the radix-2 restoring divider (33 quotient steps plus setup). The next matrix
// loads while the last result word still waits in the output register.
module matrix3_inverse_unit
    import m3i_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_element,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_inverse_element,
    output logic               m_singular,
    output logic               m_last
);

    localparam int SHIFT = 2 * FRAC_BITS + 1;
    localparam int NUM_W = 64 + SHIFT + 1;
    localparam int REM_W = (NUM_W > DET_W + 33) ? NUM_W : DET_W + 33;

    state_t state_reg, state_next;

    idx_t             cnt_reg;
    idx_t             k_reg;
    logic [PH_W-1:0]  ph_reg;
    logic [1:0]       j_reg;
    logic [BIT_W-1:0] bit_reg;
    logic             m_valid_reg;

    logic signed [OPND_W-1:0] op_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic [COF_W-1:0]         c_reg;
    logic signed [DET_W-1:0]  det_reg;
    logic [DET_W-1:0]         dv_reg;     // twice the determinant magnitude
    logic [63:0]              cmag_reg;
    logic                     neg_reg;
    logic                     ovf_reg;
    logic                     sing_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [REM_W-1:0]         dsh_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic signed [31:0]       m_inverse_element_reg;
    logic                     m_singular_reg;
    logic                     m_last_reg;

    // memory ports and shared datapath
    logic                     src_we;
    idx_t                     src_raddr;
    logic [DATA_W-1:0]        src_rdata;
    logic                     cof_we;
    idx_t                     cof_raddr;
    logic [COF_W-1:0]         cof_rdata;
    logic signed [OPND_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] cof_diff;
    logic signed [OPND_W-1:0] src_ext;
    logic [COF_W-1:0]         cof_neg;
    logic [DET_W-1:0]         det_abs;
    logic                     rem_ge;
    logic                     emit_fire;
    logic                     sat;
    logic [QUO_W-1:0]         limit;
    logic [QUO_W-1:0]         res_mag;
    logic [QUO_W-1:0]         res_val;

    m3i_ram #(.WIDTH(DATA_W), .DEPTH(ELEM_COUNT)) u_src_ram (
        .aclk  (aclk),
        .we    (src_we),
        .waddr (cnt_reg),
        .wdata (s_element),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    m3i_ram #(.WIDTH(COF_W), .DEPTH(ELEM_COUNT)) u_cof_ram (
        .aclk  (aclk),
        .we    (cof_we),
        .waddr (k_reg),
        .wdata (cof_diff[COF_W-1:0]),
        .raddr (cof_raddr),
        .rdata (cof_rdata)
    );

    assign src_ext  = $signed({src_rdata[DATA_W-1], src_rdata});
    assign mul_p    = op_reg * mul_b;
    assign cof_diff = acc_reg - prod_reg;
    assign cof_neg  = COF_W'(0) - cof_rdata;
    assign det_abs  = det_reg[DET_W-1] ? (DET_W'(0) - det_reg) : det_reg;
    assign rem_ge   = rem_reg >= dsh_reg;

    assign emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // final saturation and sign of one quotient
    assign limit   = neg_reg ? LIMIT_NEG : LIMIT_POS;
    assign sat     = ovf_reg || (quo_reg > limit);
    assign res_mag = sat ? limit : quo_reg;
    assign res_val = neg_reg ? (QUO_W'(0) - res_mag) : res_mag;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_valid && cnt_reg == idx_t'(ELEM_COUNT - 1)) begin
                    state_next = ST_COF;
                end
            end
            ST_COF: begin
                if (ph_reg == PH_W'(5) && k_reg == idx_t'(ELEM_COUNT - 1)) begin
                    state_next = ST_DET;
                end
            end
            ST_DET: begin
                if (ph_reg == PH_W'(4) && j_reg == 2'd2) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = (det_reg == '0) ? ST_EMIT : ST_PREP;
            end
            ST_PREP: begin
                if (ph_reg == PH_W'(3)) begin
                    state_next = ST_ITER;
                end
            end
            ST_ITER: begin
                if (bit_reg == '0) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    if (sing_reg || k_reg == idx_t'(ELEM_COUNT - 1)) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_PREP;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // memory addresses, strobes and multiplier operand
    always_comb begin
        s_ready   = 1'b0;
        src_raddr = COF_SEL[k_reg][0];
        cof_raddr = k_reg;
        cof_we    = 1'b0;
        mul_b     = src_ext;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
            end
            ST_COF: begin
                case (ph_reg)
                    PH_W'(1): src_raddr = COF_SEL[k_reg][1];
                    PH_W'(2): src_raddr = COF_SEL[k_reg][2];
                    PH_W'(3): src_raddr = COF_SEL[k_reg][3];
                    default:  src_raddr = COF_SEL[k_reg][0];
                endcase
                cof_we = (ph_reg == PH_W'(5));
            end
            ST_DET: begin
                src_raddr = idx_t'(j_reg);
                cof_raddr = idx_t'({j_reg, 1'b0}) + idx_t'(j_reg);
                if (ph_reg == PH_W'(2)) begin
                    mul_b = $signed({1'b0, c_reg[31:0]});
                end else begin
                    mul_b = $signed(c_reg[COF_W-1:32]);
                end
            end
            default: begin
            end
        endcase
    end

    assign src_we = s_valid && s_ready;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            k_reg       <= '0;
            ph_reg      <= '0;
            j_reg       <= '0;
            bit_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // hold the word until the sink takes it
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (src_we) begin
                        // advance the load count, wrap after the ninth word
                        if (cnt_reg == idx_t'(ELEM_COUNT - 1)) begin
                            cnt_reg <= '0;
                            k_reg   <= '0;
                            ph_reg  <= '0;
                        end else begin
                            cnt_reg <= cnt_reg + idx_t'(1);
                        end
                    end
                end
                ST_COF: begin
                    if (ph_reg == PH_W'(5)) begin
                        ph_reg <= '0;
                        if (k_reg == idx_t'(ELEM_COUNT - 1)) begin
                            k_reg <= '0;
                            j_reg <= '0;
                        end else begin
                            k_reg <= k_reg + idx_t'(1);
                        end
                    end else begin
                        ph_reg <= ph_reg + PH_W'(1);
                    end
                end
                ST_DET: begin
                    if (ph_reg == PH_W'(4)) begin
                        ph_reg <= '0;
                        j_reg  <= j_reg + 2'd1;
                    end else begin
                        ph_reg <= ph_reg + PH_W'(1);
                    end
                end
                ST_CHECK: begin
                    k_reg  <= '0;
                    ph_reg <= '0;
                end
                ST_PREP: begin
                    if (ph_reg == PH_W'(3)) begin
                        ph_reg  <= '0;
                        bit_reg <= BIT_W'(LAST_BIT);
                    end else begin
                        ph_reg <= ph_reg + PH_W'(1);
                    end
                end
                ST_ITER: begin
                    if (bit_reg != '0) begin
                        bit_reg <= bit_reg - BIT_W'(1);
                    end
                end
                ST_EMIT: begin
                    if (emit_fire) begin
                        ph_reg <= '0;
                        if (k_reg == idx_t'(ELEM_COUNT - 1)) begin
                            k_reg <= '0;
                        end else begin
                            k_reg <= k_reg + idx_t'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_COF: begin
                case (ph_reg)
                    PH_W'(1): op_reg <= src_ext;
                    PH_W'(2): prod_reg <= mul_p;
                    PH_W'(3): begin
                        acc_reg <= prod_reg;
                        op_reg  <= src_ext;
                    end
                    PH_W'(4): prod_reg <= mul_p;
                    default: begin
                    end
                endcase
                if (ph_reg == PH_W'(5) && k_reg == idx_t'(ELEM_COUNT - 1)) begin
                    det_reg <= '0;
                end
            end
            ST_DET: begin
                case (ph_reg)
                    PH_W'(1): begin
                        op_reg <= src_ext;
                        c_reg  <= cof_rdata;
                    end
                    PH_W'(2): prod_reg <= mul_p;
                    PH_W'(3): begin
                        det_reg  <= det_reg + DET_W'(prod_reg);
                        prod_reg <= mul_p;
                    end
                    PH_W'(4): det_reg <= det_reg + $signed({prod_reg, 32'b0});
                    default: begin
                    end
                endcase
            end
            ST_CHECK: begin
                sing_reg <= (det_reg == '0);
                dv_reg   <= {det_abs[DET_W-2:0], 1'b0};
            end
            ST_PREP: begin
                case (ph_reg)
                    PH_W'(1): begin
                        neg_reg  <= cof_rdata[COF_W-1] ^ det_reg[DET_W-1];
                        cmag_reg <= cof_rdata[COF_W-1] ? cof_neg[63:0] : cof_rdata[63:0];
                    end
                    PH_W'(2): begin
                        // numerator |C| * 2^(2F+1) + |D| against divisor 2|D|
                        rem_reg <= REM_W'({cmag_reg, {SHIFT{1'b0}}})
                                 + REM_W'(dv_reg >> 1);
                        dsh_reg <= REM_W'({dv_reg, 32'b0});
                    end
                    PH_W'(3): begin
                        ovf_reg <= rem_reg >= {dsh_reg[REM_W-2:0], 1'b0};
                        quo_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_ITER: begin
                if (rem_ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
                dsh_reg <= dsh_reg >> 1;
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    m_inverse_element_reg <= sing_reg ? 32'sd0 : $signed(res_val[31:0]);
                    m_singular_reg        <= sing_reg;
                    m_last_reg            <= sing_reg || (k_reg == idx_t'(ELEM_COUNT - 1));
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_inverse_element = m_inverse_element_reg;
    assign m_singular        = m_singular_reg;
    assign m_last            = m_last_reg;

    a_load_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < idx_t'(ELEM_COUNT))
        else $error("load count out of range");

    a_singular_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> m_last)
        else $error("singular word without last mark");

    a_divider_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ITER |-> bit_reg <= BIT_W'(LAST_BIT))
        else $error("divider step count out of range");

    a_cof_write_index: assert property (@(posedge aclk) disable iff (!aresetn)
        cof_we |-> k_reg < idx_t'(ELEM_COUNT) && state_reg == ST_COF)
        else $error("cofactor write out of sequence");

endmodule
